FILE: rtl/wmv_pkg.sv
// Shared types, widths and constants for the windowed mean and variance block.
package wmv_pkg;

  localparam int unsigned MAX_WINDOW       = 1048576;
  localparam int unsigned TOTAL_COUNT_BITS = 40;
  localparam int unsigned DEFAULT_WINDOW   = 44050;
  localparam int unsigned DEFAULT_EFF      =
    (DEFAULT_WINDOW > MAX_WINDOW) ? MAX_WINDOW : DEFAULT_WINDOW;

  localparam int CFG_W   = 21;
  localparam int SMP_W   = 16;
  localparam int IDX_W   = 32;
  localparam int SQA_W   = 31;
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = SMP_W + CNT_W;
  localparam int SQ_W    = 30 + CNT_W;
  localparam int DEV_W   = 32 + CNT_W;
  localparam int TSUM_W  = 56;
  localparam int TCNT_W  = TOTAL_COUNT_BITS;
  localparam int PROD1_W = SMP_W + SUM_W;
  localparam int P3_W    = CNT_W + SQA_W;
  localparam int EXT_W   = PROD1_W + 2;
  localparam int DIV_W   = (DEV_W > TSUM_W) ? DEV_W : TSUM_W;
  localparam int DVS_W   = (CNT_W > TCNT_W) ? CNT_W : TCNT_W;
  localparam int DCNT_W  = $clog2(DIV_W);

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [SQA_W-1:0]        SQ_CAP   = 31'h7FFF_FFFF;
  localparam logic signed [SMP_W-1:0] MEAN_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] MEAN_MIN = 16'sh8000;

  localparam logic KIND_WINDOW  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    end_of_stream;
  } wmv_in_t;

  typedef struct packed {
    logic                    kind;
    logic [IDX_W-1:0]        window_number;
    logic signed [SMP_W-1:0] window_mean;
    logic [SQA_W-1:0]        window_sqavg;
    logic signed [SMP_W-1:0] stream_mean;
    logic signed [SMP_W-1:0] mean_min;
    logic signed [SMP_W-1:0] mean_max;
    logic [SQA_W-1:0]        sqavg_min;
    logic [SQA_W-1:0]        sqavg_max;
    logic                    last;
  } wmv_out_t;

  // One closed window, handed from the accumulator to the back end.
  typedef struct packed {
    logic                     eos;
    logic [CNT_W-1:0]         count;
    logic signed [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]          sumsq;
    logic [IDX_W-1:0]         index;
    logic signed [TSUM_W-1:0] tsum;
    logic [TCNT_W-1:0]        tcnt;
  } wmv_job_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } wmv_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } wmv_div_rsp_t;

endpackage

FILE: rtl/wmv_front.sv
// Front end: window size register, running sums and window close detection.
module wmv_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wmv_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  wmv_pkg::wmv_in_t             in_data,
  output logic                         push,
  output wmv_pkg::wmv_job_t            push_job,
  input  logic                         q_full
);

  logic [wmv_pkg::CFG_W-1:0]         window_size_r;
  logic signed [wmv_pkg::SUM_W-1:0]  win_sum_r, win_sum_nxt;
  logic [wmv_pkg::SQ_W-1:0]          win_sumsq_r, win_sumsq_nxt;
  logic [wmv_pkg::CNT_W-1:0]         win_count_r, win_count_nxt;
  logic [wmv_pkg::IDX_W-1:0]         win_index_r;
  logic signed [wmv_pkg::TSUM_W-1:0] total_sum_r, total_sum_nxt;
  logic [wmv_pkg::TCNT_W-1:0]        total_count_r, total_count_nxt;

  logic [31:0]                       ws_ext;
  logic [wmv_pkg::CNT_W-1:0]         eff_size;
  logic signed [31:0]                sq_full;
  logic signed [wmv_pkg::TSUM_W:0]   tsum_ext;
  logic                              accept;
  logic                              close;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  assign ws_ext   = 32'(window_size_r);
  assign eff_size = (ws_ext == 32'd0) ? wmv_pkg::CNT_W'(wmv_pkg::DEFAULT_EFF) :
                    (ws_ext > 32'(wmv_pkg::MAX_WINDOW)) ?
                    wmv_pkg::CNT_W'(wmv_pkg::MAX_WINDOW) : wmv_pkg::CNT_W'(ws_ext);

  assign sq_full = 32'(in_data.sample) * 32'(in_data.sample);

  assign win_sum_nxt   = win_sum_r + wmv_pkg::SUM_W'(in_data.sample);
  assign win_sumsq_nxt = win_sumsq_r + wmv_pkg::SQ_W'(sq_full[30:0]);
  assign win_count_nxt = win_count_r + wmv_pkg::CNT_W'(1);

  // saturate the stream sum: top two bits disagree on overflow
  assign tsum_ext = (wmv_pkg::TSUM_W+1)'(total_sum_r) + (wmv_pkg::TSUM_W+1)'(in_data.sample);
  always_comb begin
    if (tsum_ext[wmv_pkg::TSUM_W] != tsum_ext[wmv_pkg::TSUM_W-1]) begin
      total_sum_nxt = tsum_ext[wmv_pkg::TSUM_W] ?
        {1'b1, {(wmv_pkg::TSUM_W-1){1'b0}}} : {1'b0, {(wmv_pkg::TSUM_W-1){1'b1}}};
    end else begin
      total_sum_nxt = tsum_ext[wmv_pkg::TSUM_W-1:0];
    end
  end

  assign total_count_nxt = (&total_count_r) ? total_count_r :
                           total_count_r + wmv_pkg::TCNT_W'(1);

  assign close = (win_count_nxt >= eff_size) || in_data.end_of_stream;
  assign push  = accept && close;

  always_comb begin
    push_job       = '0;
    push_job.eos   = in_data.end_of_stream;
    push_job.count = win_count_nxt;
    push_job.sum   = win_sum_nxt;
    push_job.sumsq = win_sumsq_nxt;
    push_job.index = win_index_r;
    push_job.tsum  = total_sum_nxt;
    push_job.tcnt  = total_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= wmv_pkg::CFG_W'(wmv_pkg::DEFAULT_WINDOW);
    end else if (cfg_valid) begin
      window_size_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_sum_r     <= '0;
      win_sumsq_r   <= '0;
      win_count_r   <= '0;
      win_index_r   <= '0;
      total_sum_r   <= '0;
      total_count_r <= '0;
    end else if (accept) begin
      if (in_data.end_of_stream) begin
        win_sum_r     <= '0;
        win_sumsq_r   <= '0;
        win_count_r   <= '0;
        win_index_r   <= '0;
        total_sum_r   <= '0;
        total_count_r <= '0;
      end else if (close) begin
        win_sum_r     <= '0;
        win_sumsq_r   <= '0;
        win_count_r   <= '0;
        win_index_r   <= win_index_r + wmv_pkg::IDX_W'(1);
        total_sum_r   <= total_sum_nxt;
        total_count_r <= total_count_nxt;
      end else begin
        win_sum_r     <= win_sum_nxt;
        win_sumsq_r   <= win_sumsq_nxt;
        win_count_r   <= win_count_nxt;
        total_sum_r   <= total_sum_nxt;
        total_count_r <= total_count_nxt;
      end
    end
  end

endmodule

FILE: rtl/wmv_queue.sv
// Short queue of closed windows between the front and back ends.
module wmv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wmv_pkg::wmv_job_t push_job,
  output logic              full,
  input  logic              pop,
  output wmv_pkg::wmv_job_t head,
  output logic              empty
);

  wmv_pkg::wmv_job_t          entry_r [wmv_pkg::QDEPTH];
  logic [wmv_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [wmv_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [wmv_pkg::QCNT_W-1:0] count_r;

  assign full  = (count_r == wmv_pkg::QCNT_W'(wmv_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == wmv_pkg::QPTR_W'(wmv_pkg::QDEPTH-1)) ? '0 :
                    wr_ptr_r + wmv_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == wmv_pkg::QPTR_W'(wmv_pkg::QDEPTH-1)) ? '0 :
                    rd_ptr_r + wmv_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + wmv_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - wmv_pkg::QCNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");

endmodule

FILE: rtl/wmv_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module wmv_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wmv_pkg::wmv_div_req_t req,
  output wmv_pkg::wmv_div_rsp_t rsp
);

  logic [wmv_pkg::DIV_W-1:0]  quo_r;
  logic [wmv_pkg::DVS_W-1:0]  rem_r;
  logic [wmv_pkg::DVS_W-1:0]  dvs_r;
  logic [wmv_pkg::DCNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [wmv_pkg::DVS_W:0]    shifted;
  logic [wmv_pkg::DVS_W:0]    diff;
  logic                       fits;

  assign shifted = {rem_r, quo_r[wmv_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
      cnt_r <= wmv_pkg::DCNT_W'(wmv_pkg::DIV_W - 1);
    end else if (busy_r) begin
      quo_r <= {quo_r[wmv_pkg::DIV_W-2:0], fits};
      rem_r <= fits ? diff[wmv_pkg::DVS_W-1:0] : shifted[wmv_pkg::DVS_W-1:0];
      cnt_r <= cnt_r - wmv_pkg::DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/wmv_back.sv
// Back end: per-window mean and deviation, running extremes, stream summary, result register.
module wmv_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wmv_pkg::wmv_job_t     q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output wmv_pkg::wmv_div_req_t div_req,
  input  wmv_pkg::wmv_div_rsp_t div_rsp,
  output logic                  out_valid,
  input  logic                  out_ready,
  output wmv_pkg::wmv_out_t     out_data
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DIV_MEAN = 9'b000000010,
    ST_MUL      = 9'b000000100,
    ST_ACC      = 9'b000001000,
    ST_DEV      = 9'b000010000,
    ST_DIV_SQ   = 9'b000100000,
    ST_WIN_OUT  = 9'b001000000,
    ST_DIV_TOT  = 9'b010000000,
    ST_SUM_OUT  = 9'b100000000
  } back_state_t;

  back_state_t                         state_r;
  wmv_pkg::wmv_job_t                   job_r;
  logic signed [wmv_pkg::SMP_W-1:0]    a_r;
  logic signed [wmv_pkg::PROD1_W-1:0]  p1_r;
  logic [wmv_pkg::SQA_W-1:0]           p2_r;
  logic signed [wmv_pkg::EXT_W-1:0]    t_r;
  logic [wmv_pkg::P3_W-1:0]            p3_r;
  logic [wmv_pkg::SQA_W-1:0]           q_r;
  logic signed [wmv_pkg::SMP_W-1:0]    m_r;
  logic signed [wmv_pkg::SMP_W-1:0]    mean_lo_r;
  logic signed [wmv_pkg::SMP_W-1:0]    mean_hi_r;
  logic [wmv_pkg::SQA_W-1:0]           sq_lo_r;
  logic [wmv_pkg::SQA_W-1:0]           sq_hi_r;
  logic                                out_valid_r;
  wmv_pkg::wmv_out_t                   out_data_r;
  wmv_pkg::wmv_out_t                   out_data_nxt;

  logic                                out_free;
  logic                                ld_win;
  logic                                ld_sum;
  logic [wmv_pkg::SUM_W-1:0]           head_mag;
  logic [wmv_pkg::TSUM_W-1:0]          tsum_mag;
  logic signed [wmv_pkg::EXT_W-1:0]    d_val;
  logic signed [31:0]                  aa_full;
  logic [wmv_pkg::DIV_W-1:0]           quo;
  logic [16:0]                         a_val;
  logic [wmv_pkg::SMP_W-1:0]           m_neg;
  logic signed [wmv_pkg::SMP_W-1:0]    m_val;
  logic [wmv_pkg::SQA_W-1:0]           q_val;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign quo       = div_rsp.quotient;

  assign q_pop  = (state_r == ST_IDLE) && !q_empty;
  assign ld_win = (state_r == ST_WIN_OUT) && out_free;
  assign ld_sum = (state_r == ST_SUM_OUT) && out_free;

  assign head_mag = q_head.sum[wmv_pkg::SUM_W-1] ? wmv_pkg::SUM_W'(-q_head.sum) :
                    wmv_pkg::SUM_W'(q_head.sum);
  assign tsum_mag = job_r.tsum[wmv_pkg::TSUM_W-1] ? wmv_pkg::TSUM_W'(-job_r.tsum) :
                    wmv_pkg::TSUM_W'(job_r.tsum);

  // sum of squared deviations: Q - 2aS + n*a*a, never negative
  assign d_val   = t_r + $signed({{(wmv_pkg::EXT_W-wmv_pkg::P3_W){1'b0}}, p3_r});
  assign aa_full = 32'(a_r) * 32'(a_r);

  // |S|/n never exceeds 32768, so 17 bits carry the signed mean
  assign a_val = job_r.sum[wmv_pkg::SUM_W-1] ? -quo[16:0] : quo[16:0];
  assign q_val = (quo > wmv_pkg::DIV_W'(wmv_pkg::SQ_CAP)) ? wmv_pkg::SQ_CAP :
                 quo[wmv_pkg::SQA_W-1:0];
  assign m_neg = -quo[wmv_pkg::SMP_W-1:0];

  always_comb begin
    if (job_r.tsum[wmv_pkg::TSUM_W-1]) begin
      m_val = (quo >= wmv_pkg::DIV_W'(32768)) ? wmv_pkg::MEAN_MIN : $signed(m_neg);
    end else begin
      m_val = (quo > wmv_pkg::DIV_W'(32767)) ? wmv_pkg::MEAN_MAX :
              $signed(quo[wmv_pkg::SMP_W-1:0]);
    end
  end

  always_comb begin
    div_req = '0;
    unique case (state_r)
      ST_IDLE: begin
        div_req.start    = !q_empty;
        div_req.dividend = wmv_pkg::DIV_W'(head_mag);
        div_req.divisor  = wmv_pkg::DVS_W'(q_head.count);
      end
      ST_DEV: begin
        div_req.start    = 1'b1;
        div_req.dividend = wmv_pkg::DIV_W'(d_val[wmv_pkg::DEV_W-1:0]);
        div_req.divisor  = wmv_pkg::DVS_W'(job_r.count);
      end
      ST_WIN_OUT: begin
        div_req.start    = out_free && job_r.eos;
        div_req.dividend = wmv_pkg::DIV_W'(tsum_mag);
        div_req.divisor  = wmv_pkg::DVS_W'(job_r.tcnt);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE:     if (!q_empty) state_r <= ST_DIV_MEAN;
        ST_DIV_MEAN: if (div_rsp.done) state_r <= ST_MUL;
        ST_MUL:      state_r <= ST_ACC;
        ST_ACC:      state_r <= ST_DEV;
        ST_DEV:      state_r <= ST_DIV_SQ;
        ST_DIV_SQ:   if (div_rsp.done) state_r <= ST_WIN_OUT;
        ST_WIN_OUT: begin
          if (out_free) state_r <= job_r.eos ? ST_DIV_TOT : ST_IDLE;
        end
        ST_DIV_TOT:  if (div_rsp.done) state_r <= ST_SUM_OUT;
        ST_SUM_OUT:  if (out_free) state_r <= ST_IDLE;
        default:     state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
    if ((state_r == ST_DIV_MEAN) && div_rsp.done) begin
      a_r <= $signed(a_val[wmv_pkg::SMP_W-1:0]);
    end
    if (state_r == ST_MUL) begin
      p1_r <= wmv_pkg::PROD1_W'(a_r) * wmv_pkg::PROD1_W'(job_r.sum);
      p2_r <= aa_full[wmv_pkg::SQA_W-1:0];
    end
    if (state_r == ST_ACC) begin
      t_r  <= $signed({{(wmv_pkg::EXT_W-wmv_pkg::SQ_W){1'b0}}, job_r.sumsq})
              - (wmv_pkg::EXT_W'(p1_r) <<< 1);
      p3_r <= wmv_pkg::P3_W'(job_r.count) * wmv_pkg::P3_W'(p2_r);
    end
    if ((state_r == ST_DIV_SQ) && div_rsp.done) begin
      q_r <= q_val;
    end
    if ((state_r == ST_DIV_TOT) && div_rsp.done) begin
      m_r <= m_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_lo_r <= wmv_pkg::MEAN_MAX;
      mean_hi_r <= wmv_pkg::MEAN_MIN;
      sq_lo_r   <= wmv_pkg::SQ_CAP;
      sq_hi_r   <= '0;
    end else if (ld_sum) begin
      mean_lo_r <= wmv_pkg::MEAN_MAX;
      mean_hi_r <= wmv_pkg::MEAN_MIN;
      sq_lo_r   <= wmv_pkg::SQ_CAP;
      sq_hi_r   <= '0;
    end else if (ld_win) begin
      if (a_r < mean_lo_r) mean_lo_r <= a_r;
      if (a_r > mean_hi_r) mean_hi_r <= a_r;
      if (q_r < sq_lo_r)   sq_lo_r   <= q_r;
      if (q_r > sq_hi_r)   sq_hi_r   <= q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_win || ld_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (ld_win) begin
      out_data_nxt.kind          = wmv_pkg::KIND_WINDOW;
      out_data_nxt.window_number = job_r.index;
      out_data_nxt.window_mean   = a_r;
      out_data_nxt.window_sqavg  = q_r;
    end else begin
      out_data_nxt.kind          = wmv_pkg::KIND_SUMMARY;
      out_data_nxt.window_number = job_r.index + wmv_pkg::IDX_W'(1);
      out_data_nxt.stream_mean   = m_r;
      out_data_nxt.mean_min      = mean_lo_r;
      out_data_nxt.mean_max      = mean_hi_r;
      out_data_nxt.sqavg_min     = sq_lo_r;
      out_data_nxt.sqavg_max     = sq_hi_r;
      out_data_nxt.last          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_win || ld_sum) begin
      out_data_r <= out_data_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_MEAN) || (state_r == ST_DIV_SQ) ||
                     (state_r == ST_DIV_TOT))
    else $error("divider finished outside a divide step");
  assert property (@(posedge clk) disable iff (!rst_n)
    ld_win |=> (mean_lo_r <= mean_hi_r) && (sq_lo_r <= sq_hi_r))
    else $error("window extremes out of order after an update");
  assert property (@(posedge clk) disable iff (!rst_n) ld_sum |-> job_r.eos)
    else $error("summary built for a window without end of stream");

endmodule

FILE: rtl/windowed_mean_variance.sv
// Top level of the windowed mean and variance block.
// Samples are accepted one per cycle, while in_ready is high, into running
// window sums; no sample is stored. When a window closes (count reaches the
// window size, or the end_of_stream sample arrives) its sums go into a
// 4-entry queue and a back end works out the mean and mean squared deviation
// with a shared restoring divider (a load, then one quotient bit per cycle);
// an end-of-stream summary takes a further divide for the stream mean. Input
// runs at one sample per cycle as long as windows are long enough for the
// back end to keep up; with shorter windows the queue fills and in_ready drops
// until the divider catches up. The result register lets the back end go on
// with the next window while a result waits on out_ready. The window size
// register takes a write in any cycle; size zero means 44050, sizes above
// 1048576 are limited.
module windowed_mean_variance (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [wmv_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  wmv_pkg::wmv_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output wmv_pkg::wmv_out_t         out_data
);

  logic                  push;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  wmv_pkg::wmv_job_t     push_job;
  wmv_pkg::wmv_job_t     q_head;
  wmv_pkg::wmv_div_req_t div_req;
  wmv_pkg::wmv_div_rsp_t div_rsp;

  wmv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  wmv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  wmv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  wmv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
